>>> rtl/core/mpsa_pkg.sv
// shared types and constants for the masked plane stack averager
// no dependencies; imported by mpsa_div and masked_plane_stack_average
package mpsa_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int SUM_W      = 40;
	localparam int CNT_W      = 9;
	localparam int PIX_W      = 12;
	localparam int PPP_W      = 13;
	localparam int MASK_W     = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int STEP_W     = $clog2(SUM_W);

	localparam logic [CNT_W-1:0] PLANE_LIMIT = 9'd256;

	localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_PLANE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_CODE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_MIDLOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_MIDHIGH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH        = 3'd5;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	typedef struct packed {
		logic                       req_type;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       not_finite;
		logic        [PIX_W-1:0]    read_pixel;
	} req_item_t;

	typedef struct packed {
		logic        [PIX_W-1:0]    out_pixel;
		logic signed [SAMPLE_W-1:0] mean_value;
		logic                       is_blank;
		logic        [CNT_W-1:0]    valid_count;
	} rsp_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic        [CNT_W-1:0] count;
	} store_entry_t;

	typedef struct packed {
		logic                 start;
		logic [SUM_W-1:0]     dividend;
		logic [CNT_W-1:0]     divisor;
		logic                 negate;
	} div_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [SAMPLE_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/core/mpsa_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module mpsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/mpsa_div.sv
// iterative signed divider, magnitude of the sum over a positive count
// one restoring step per cycle, then a sign fix step; uses mpsa_pkg
module mpsa_div
	import mpsa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	logic                       busy_q;
	logic                       fix_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [CNT_W-1:0]           rem_q;
	logic [SUM_W-1:0]           quo_q;
	logic [CNT_W-1:0]           div_q;
	logic                       neg_q;
	logic signed [SAMPLE_W-1:0] result_q;

	logic [CNT_W:0] rem_shift;
	logic [CNT_W:0] rem_diff;
	logic           fits;

	always_comb begin
		rem_shift = {rem_q, quo_q[SUM_W-1]};
		fits      = rem_shift >= {1'b0, div_q};
		rem_diff  = rem_shift - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
			neg_q <= req.negate;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end else if (fix_q) begin
			// truncation toward zero: negate the magnitude quotient
			result_q <= neg_q ? -$signed(quo_q[SAMPLE_W-1:0])
			                  :  $signed(quo_q[SAMPLE_W-1:0]);
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = result_q;

endmodule

>>> rtl/core/masked_plane_stack_average.sv
// masked plane stack averager: a sample transfer does a store read, then a store write;
// a readout with a nonzero count runs the store read, the 40 step serial divider and a
// sign fix before rsp_valid; an empty pixel skips the divider; no new request is taken meanwhile
// a finished readout waits while the output register holds an unaccepted result
// after reset a clearing pass writes zero to all MAX_PIXELS store entries, one per cycle,
// with req_ready low; config writes are taken throughout
module masked_plane_stack_average
	import mpsa_pkg::*;
#(
	parameter int MAX_PIXELS = 4096,
	parameter int MAX_FRAMES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_item_t             req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_item_t             rsp_data
);

	// store address width, width holding MAX_PIXELS, and compare width
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int PW = $clog2(MAX_PIXELS + 1);
	localparam int CW = (PW > PPP_W) ? PW : PPP_W;
	localparam int EW = SUM_W + CNT_W;

	localparam logic [CW-1:0] MAX_PIX_C  = CW'(MAX_PIXELS);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(MAX_PIXELS - 1);
	localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(MAX_FRAMES);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SERVE = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// configuration
	logic [PPP_W-1:0]           ppp_q;
	logic signed [SAMPLE_W-1:0] blank_q;
	logic [MASK_W-1:0]          mask_low_q;
	logic [MASK_W-1:0]          mask_midlow_q;
	logic [MASK_W-1:0]          mask_midhigh_q;
	logic [MASK_W-1:0]          mask_high_q;

	// control
	logic [2:0]       state_q;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    pix_q;
	logic [CNT_W-1:0] plane_q;
	logic             rsp_valid_q;

	// accepted item and result holding
	req_item_t                  req_s1;
	logic [AW-1:0]              addr_s1;
	logic                       acc_en_s1;
	logic                       oob_s1;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic                       blank_flag_q;
	logic [CNT_W-1:0]           count_q;
	rsp_item_t                  rsp_q;

	// combinational
	logic          req_fire;
	logic          rsp_free;
	logic [4*MASK_W-1:0] mask_all;
	logic          plane_sel;
	logic [CW-1:0] plane_size;
	logic [CW-1:0] pix_next;
	logic          wrap;
	logic [CW-1:0] read_ext;
	logic          read_oob;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	store_entry_t  wr_entry;
	store_entry_t  rd_entry;
	logic [EW-1:0] rd_raw;
	logic          serve_read;
	logic          empty;
	div_req_t      div_req;
	div_rsp_t      div_rsp;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		mask_all = {mask_high_q, mask_midhigh_q, mask_midlow_q, mask_low_q};
		// planes at or past the limit or MAX_FRAMES are never selected
		plane_sel = (plane_q < PLANE_LIMIT) && (plane_q < FRAMES_C) &&
		            mask_all[plane_q[7:0]];
		// zero or oversized plane size falls back to the full store
		if ((ppp_q == '0) || (CW'(ppp_q) > MAX_PIX_C)) begin
			plane_size = MAX_PIX_C;
		end else begin
			plane_size = CW'(ppp_q);
		end
		pix_next = CW'(pix_q) + CW'(1);
		wrap     = pix_next >= plane_size;
		read_ext = CW'(req_data.read_pixel);
		read_oob = read_ext >= MAX_PIX_C;
		// store read issued in the accept cycle
		rd_addr  = (req_data.req_type == REQ_READ) ? read_ext[AW-1:0] : pix_q;
	end

	assign rd_entry   = store_entry_t'(rd_raw);
	assign serve_read = (state_q == ST_SERVE) && (req_s1.req_type == REQ_READ);
	assign empty      = oob_s1 || (rd_entry.count == '0);

	// store writes: clearing pass, or read-modify-write of one sample
	always_comb begin
		wr_en          = 1'b0;
		wr_addr        = addr_s1;
		wr_entry.sum   = rd_entry.sum + SUM_W'(req_s1.sample);
		wr_entry.count = rd_entry.count + CNT_W'(1);
		if (state_q == ST_CLEAR) begin
			wr_en    = 1'b1;
			wr_addr  = clr_q;
			wr_entry = '0;
		end else if ((state_q == ST_SERVE) && (req_s1.req_type == REQ_SAMPLE)) begin
			// a saturated count drops the sample
			wr_en = acc_en_s1 && (rd_entry.count < PLANE_LIMIT);
		end
	end

	// divider request, magnitude in, sign applied at the end
	always_comb begin
		div_req.start    = serve_read && !empty;
		div_req.negate   = rd_entry.sum[SUM_W-1];
		div_req.divisor  = rd_entry.count;
		div_req.dividend = rd_entry.sum[SUM_W-1] ? SUM_W'(-rd_entry.sum)
		                                         : SUM_W'(rd_entry.sum);
	end

	mpsa_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_PIXELS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(EW'(wr_entry)),
		.raddr(rd_addr),
		.rdata(rd_raw)
	);

	mpsa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// configuration registers, writes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppp_q          <= 13'd4096;
			blank_q        <= 32'sh8000_0000;
			mask_low_q     <= '1;
			mask_midlow_q  <= '1;
			mask_midhigh_q <= '1;
			mask_high_q    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXELS_PER_PLANE: ppp_q          <= cfg_data[PPP_W-1:0];
				REG_BLANK_CODE:       blank_q        <= $signed(cfg_data[SAMPLE_W-1:0]);
				REG_MASK_LOW:         mask_low_q     <= cfg_data;
				REG_MASK_MIDLOW:      mask_midlow_q  <= cfg_data;
				REG_MASK_MIDHIGH:     mask_midhigh_q <= cfg_data;
				REG_MASK_HIGH:        mask_high_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pix_q       <= '0;
			plane_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a finished readout loads the output register once it is free
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_SERVE;
						// every sample moves the position, accumulated or not
						if (req_data.req_type == REQ_SAMPLE) begin
							if (wrap) begin
								pix_q <= '0;
								if (plane_q < PLANE_LIMIT) begin
									plane_q <= plane_q + CNT_W'(1);
								end
							end else begin
								pix_q <= pix_next[AW-1:0];
							end
						end
					end
				end
				ST_SERVE: begin
					if (req_s1.req_type == REQ_SAMPLE) begin
						state_q <= ST_IDLE;
					end else if (empty) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1    <= req_data;
			addr_s1   <= pix_q;
			oob_s1    <= read_oob;
			acc_en_s1 <= plane_sel && !req_data.not_finite && (req_data.sample != blank_q);
		end
		if (serve_read) begin
			count_q      <= empty ? '0 : rd_entry.count;
			blank_flag_q <= empty;
			mean_q       <= blank_q;
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			mean_q <= div_rsp.quotient;
		end
		if ((state_q == ST_DONE) && rsp_free) begin
			rsp_q.out_pixel   <= req_s1.read_pixel;
			rsp_q.mean_value  <= mean_q;
			rsp_q.is_blank    <= blank_flag_q;
			rsp_q.valid_count <= count_q;
		end
	end

endmodule
